// ===== sv/hsmd_pkg.sv =====
// Shared constants and types for the haptic spring-mass-damper block.
`default_nettype none

package hsmd_pkg;

  // Width of the configuration register index and of each register.
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CoefW     = 32;

  // Default data width: signed Q16.16.
  localparam int unsigned DataWidthDefault = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    REG_SPRING_K          = 8'd0,
    REG_DAMPING_B         = 8'd1,
    REG_TIME_STEP         = 8'd2,
    REG_STEP_OVER_INERTIA = 8'd3
  } reg_index_e;

  // Register values after reset.
  localparam logic [CoefW-1:0] SpringKReset         = 32'd1165084;
  localparam logic [CoefW-1:0] DampingBReset        = 32'd1165;
  localparam logic [CoefW-1:0] TimeStepReset        = 32'd4294967;
  localparam logic [CoefW-1:0] StepOverInertiaReset = 32'd9537490;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

endpackage : hsmd_pkg

`default_nettype wire

// ===== sv/haptic_spring_mass_damper_sim_top.sv =====
// Top level of the haptic spring-mass-damper world with one shared multiplier.
// A word is taken while the sequencer is idle. In the run state it computes four scaled
// products (two 32x32 passes each through the single multiplier), and in the out state
// it loads the torque word into the output register. A new word is taken only once the
// sequencer is idle again, so the input stalls while a word is in work and also while
// the output register still holds an unread, stalled word. Reset (asynchronous, active
// low) restores the register defaults and zeroes the mass angle and velocity.
`default_nettype none

module haptic_spring_mass_damper_sim_top #(
  parameter int unsigned DATA_WIDTH = hsmd_pkg::DataWidthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write channel.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [hsmd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [hsmd_pkg::CoefW-1:0]     cfg_data_i,
  // Input channel: measured wheel state.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [31:0]             wheel_angle_i,
  input  wire logic signed [31:0]             wheel_velocity_i,
  // Output channel: commanded torque.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [31:0]                  torque_o
);
  import hsmd_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  // Wide working width for sums and saturation.
  localparam int unsigned SW = 64;
  // Signed width of a capped product: magnitude up to 2^60 plus a sign.
  localparam int unsigned PW = 62;
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] LastStep = 4'd9;

  localparam logic signed [SW-1:0] DataMax = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [SW-1:0] DataMin = -DataMax - 64'sd1;
  localparam logic signed [SW-1:0] OutMax  = 64'sd2147483647;
  localparam logic signed [SW-1:0] OutMin  = -64'sd2147483648;

  localparam logic [63:0] ProdCap  = 64'd1 << 60;
  localparam logic [63:0] CapHi16  = 64'd1 << 44;

  // Clamp a wide signed value into the data range.
  function automatic logic signed [DW-1:0] sat_data(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    begin
      r = v;
      if (v > DataMax) r = DataMax;
      if (v < DataMin) r = DataMin;
      sat_data = r[DW-1:0];
    end
  endfunction

  // Clamp a wide signed value into the 32-bit output range.
  function automatic logic signed [31:0] sat_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    begin
      r = v;
      if (v > OutMax) r = OutMax;
      if (v < OutMin) r = OutMin;
      sat_out = r[31:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always accepted; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [CoefW-1:0] spring_k_q, damping_b_q, time_step_q, step_over_inertia_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_k_q          <= SpringKReset;
      damping_b_q         <= DampingBReset;
      time_step_q         <= TimeStepReset;
      step_over_inertia_q <= StepOverInertiaReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SPRING_K:          spring_k_q          <= cfg_data_i;
        REG_DAMPING_B:         damping_b_q         <= cfg_data_i;
        REG_TIME_STEP:         time_step_q         <= cfg_data_i;
        REG_STEP_OVER_INERTIA: step_over_inertia_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. Each product a*c takes a low pass and a high pass through the
  // multiplier, then a finish step that shifts, caps and applies the sign.
  // The finish of one product overlaps the low pass of the next:
  //   step 0..1  spring product passes      step 2  finish spring  -> p
  //   step 2..3  damper product passes      step 4  finish damper  -> q
  //   step 4..5  angle update passes        step 5  torque = sat(p + q)
  //   step 6..7  velocity update passes     step 6  finish angle   -> p
  //   step 7     mass angle += p            step 8  finish velocity -> q
  //   step 9     mass velocity -= q
  // ---------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [StepW-1:0] step_q;
  logic             in_fire;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Latched inputs and the mass state.
  logic signed [DW-1:0] ang_q, vel_q;
  logic signed [DW-1:0] mass_angle_q, mass_velocity_q;
  logic signed [DW-1:0] torque_q;
  logic signed [PW-1:0] p_q, q_q;
  logic [63:0]          mult_q, pl_q;
  logic                 neg_q;
  logic                 out_valid_q;
  logic signed [31:0]   torque_out_q;
  logic                 out_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_RUN;
      ST_RUN:  if (step_q == LastStep) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RUN) begin
        step_q <= step_q + 4'd1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Operand selection: the product in progress is step_q[2:1] on steps 0..7.
  logic [1:0]           op;
  logic signed [DW:0]   op_a;
  logic [CoefW-1:0]     op_c;
  logic [DW:0]          op_mag;
  logic [63:0]          mag64;
  logic [31:0]          mul_a;

  assign op = step_q[2:1];

  always_comb begin
    op_a = '0;
    op_c = '0;
    case (op)
      2'd0: begin
        op_a = {mass_angle_q[DW-1], mass_angle_q} - {ang_q[DW-1], ang_q};
        op_c = spring_k_q;
      end
      2'd1: begin
        op_a = {mass_velocity_q[DW-1], mass_velocity_q} - {vel_q[DW-1], vel_q};
        op_c = damping_b_q;
      end
      2'd2: begin
        op_a = {mass_velocity_q[DW-1], mass_velocity_q};
        op_c = time_step_q;
      end
      default: begin
        op_a = {torque_q[DW-1], torque_q};
        op_c = step_over_inertia_q;
      end
    endcase
  end

  assign op_mag = op_a[DW] ? (~op_a + 1'b1) : op_a;
  assign mag64  = {{(64-DW-1){1'b0}}, op_mag};
  assign mul_a  = step_q[0] ? mag64[63:32] : mag64[31:0];

  // Finish step: combine the two partial products, truncate toward zero by
  // working on the magnitude, cap it at 2^60, then restore the sign.
  logic        sh16;
  logic [63:0] fin_sum, fin_mag;
  logic signed [PW-1:0] fin_val;

  assign sh16 = (step_q == 4'd2) || (step_q == 4'd4);

  always_comb begin
    if (sh16) begin
      fin_sum = {mult_q[47:0], 16'b0} + (pl_q >> 16);
    end else begin
      fin_sum = mult_q + (pl_q >> 32);
    end
    if (mult_q > (sh16 ? CapHi16 : ProdCap)) begin
      fin_mag = ProdCap;
    end else if (fin_sum > ProdCap) begin
      fin_mag = ProdCap;
    end else begin
      fin_mag = fin_sum;
    end
    fin_val = neg_q ? -$signed(fin_mag[PW-1:0]) : $signed(fin_mag[PW-1:0]);
  end

  // Datapath registers; none of them needs reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ang_q <= sat_data({{(SW-32){wheel_angle_i[31]}}, wheel_angle_i});
      vel_q <= sat_data({{(SW-32){wheel_velocity_i[31]}}, wheel_velocity_i});
    end
    if (state_q == ST_RUN) begin
      if (step_q < 4'd8) begin
        mult_q <= {32'b0, mul_a} * {32'b0, op_c};
      end
      if (step_q[0] && step_q < 4'd8) begin
        pl_q  <= mult_q;
        neg_q <= op_a[DW];
      end
      case (step_q)
        4'd2, 4'd6: p_q <= fin_val;
        4'd4, 4'd8: q_q <= fin_val;
        default: ;
      endcase
      if (step_q == 4'd5) begin
        torque_q <= sat_data({{(SW-PW){p_q[PW-1]}}, p_q} + {{(SW-PW){q_q[PW-1]}}, q_q});
      end
    end
  end

  // Mass state: cleared by reset, advanced at the end of each tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_angle_q    <= '0;
      mass_velocity_q <= '0;
    end else if (state_q == ST_RUN) begin
      if (step_q == 4'd7) begin
        mass_angle_q <= sat_data({{(SW-DW){mass_angle_q[DW-1]}}, mass_angle_q}
                                 + {{(SW-PW){p_q[PW-1]}}, p_q});
      end
      if (step_q == LastStep) begin
        mass_velocity_q <= sat_data({{(SW-DW){mass_velocity_q[DW-1]}}, mass_velocity_q}
                                    - {{(SW-PW){q_q[PW-1]}}, q_q});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. The torque word waits here while a new word may already be
  // accepted; the sequencer only blocks if the previous word is still unread.
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      torque_out_q <= sat_out({{(SW-DW){torque_q[DW-1]}}, torque_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign torque_o    = torque_out_q;

endmodule : haptic_spring_mass_damper_sim_top

`default_nettype wire

// ===== sv/hsmd_check.sv =====
// Port-level checker for the haptic spring-mass-damper block, bound to the top level.
`default_nettype none

module hsmd_check (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic signed [31:0]             torque_o
);
  logic in_fire;
  assign in_fire = in_valid_i && !in_stall_o;

  // A stalled torque word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(torque_o))
    else $error("stalled torque word changed");

  // Once a word is taken the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input not stalled while a word is in work");

  // Finishing a word always leaves its torque in the output register.
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("block became free without a result");

  // A result cannot appear right after a word is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_fire))
    else $error("result appeared one cycle after accept");

endmodule : hsmd_check

bind haptic_spring_mass_damper_sim_top hsmd_check u_hsmd_check (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the haptic spring-mass-damper torque block.
`timescale 1ns / 100ps

// Tracks the virtual mass and the coefficient registers, and holds the torque
// words still owed by the block in the order they must come back.
class torque_scoreboard;
  logic [31:0] spring_k;
  logic [31:0] damping_b;
  logic [31:0] time_step;
  logic [31:0] step_over_inertia;
  longint mass_angle;
  longint mass_velocity;
  logic signed [31:0] torque_due[$];
  int unsigned errors;
  int unsigned words_checked;

  function new();
    spring_k          = hsmd_pkg::SpringKReset;
    damping_b         = hsmd_pkg::DampingBReset;
    time_step         = hsmd_pkg::TimeStepReset;
    step_over_inertia = hsmd_pkg::StepOverInertiaReset;
    mass_angle        = 0;
    mass_velocity     = 0;
    errors            = 0;
    words_checked     = 0;
  endfunction

  static function longint clamp(longint v, int unsigned bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Signed value times unsigned coefficient, shifted right; the magnitude is
  // truncated before the sign goes back on, and it is capped at 2^60.
  static function longint scaled(longint a, logic [31:0] c, int unsigned sh);
    bit neg;
    bit [63:0] mag;
    bit [95:0] prod;
    neg = (a < 0);
    mag = neg ? 64'(-a) : 64'(a);
    prod = (96'(mag) * 96'(c)) >> sh;
    if (prod > (96'(1) << 60)) prod = 96'(1) << 60;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function void write_reg(logic [hsmd_pkg::CfgIndexW-1:0] idx, logic [31:0] val);
    case (idx)
      hsmd_pkg::REG_SPRING_K:          spring_k = val;
      hsmd_pkg::REG_DAMPING_B:         damping_b = val;
      hsmd_pkg::REG_TIME_STEP:         time_step = val;
      hsmd_pkg::REG_STEP_OVER_INERTIA: step_over_inertia = val;
      default: ;
    endcase
  endfunction

  function void note_input(logic signed [31:0] ang_in, logic signed [31:0] vel_in);
    longint ang;
    longint vel;
    longint ma;
    longint mv;
    longint trq;
    ang = clamp(longint'(ang_in), hsmd_pkg::DataWidthDefault);
    vel = clamp(longint'(vel_in), hsmd_pkg::DataWidthDefault);
    ma  = mass_angle;
    mv  = mass_velocity;
    // Torque comes from the mass state as it stood before this tick.
    trq = clamp(scaled(ma - ang, spring_k, 16) + scaled(mv - vel, damping_b, 16),
                hsmd_pkg::DataWidthDefault);
    mass_angle    = clamp(ma + scaled(mv, time_step, 32), hsmd_pkg::DataWidthDefault);
    mass_velocity = clamp(mv - scaled(trq, step_over_inertia, 32),
                          hsmd_pkg::DataWidthDefault);
    torque_due.push_back(32'(clamp(trq, 32)));
  endfunction

  function void check_result(logic signed [31:0] got);
    logic signed [31:0] want;
    if (torque_due.size() == 0) begin
      $error("torque: no word expected, got %0d", got);
      errors++;
      return;
    end
    want = torque_due.pop_front();
    words_checked++;
    if (got !== want) begin
      $error("torque: expected %0d, got %0d", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return torque_due.size();
  endfunction
endclass

module tb;
  import hsmd_pkg::*;

  // Settle time after the last torque word is back, in clock cycles.
  localparam int DrainCycles = 16;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 500000;
  localparam int PhaseWords  = 100;

  // Receiver behavior, picked afresh at random.
  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_e;

  localparam logic signed [31:0] Extremes [5] =
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001};

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CoefW-1:0]     cfg_data  = '0;

  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic signed [31:0] wheel_angle    = '0;
  logic signed [31:0] wheel_velocity = '0;

  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] torque;

  torque_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned hold_reqs   = 0;
  int unsigned settings_applied = 0;

  // Trajectory of a wheel that moves smoothly, as a real servo loop would see it.
  int traj_ang = 0;
  int traj_vel = 0;

  always #5 clk_i = ~clk_i;

  haptic_spring_mass_damper_sim_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .wheel_angle_i    (wheel_angle),
    .wheel_velocity_i (wheel_velocity),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .torque_o         (torque)
  );

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("haptic_spring_mass_damper_sim_top: mismatch");
      $finish;
    end
  end

  // Receiver: checks every accepted torque word and drives the stall. It
  // switches between free flow, light and heavy random stalls and a fixed
  // on/off rhythm. A hold-off request makes it stall for a long stretch so
  // that the block backs up and stalls its own input.
  rx_mode_e    rx_mode   = RX_FLOW;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  int unsigned rx_tick   = 0;

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      sb.check_result(torque);
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(RX_FLOW, RX_BURSTY));
      mode_left = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FLOW:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= rx_tick[2];
      endcase
    end
  end

  // Offers one wheel word and holds it until the block takes it. Valid stays
  // high on return so that back-to-back words need no extra cycle.
  task automatic send_word(input logic signed [31:0] ang, input logic signed [31:0] vel);
    wheel_angle    <= ang;
    wheel_velocity <= vel;
    in_valid       <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(ang, vel);
  endtask

  // Register write; the caller lowers valid once its batch of writes is done.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CoefW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Loads a full coefficient set. A write to an unused index goes first and
  // must leave every coefficient untouched.
  task automatic apply_setting(input logic [CoefW-1:0] k, input logic [CoefW-1:0] b,
                               input logic [CoefW-1:0] ts, input logic [CoefW-1:0] soi);
    write_reg(CfgIndexW'($urandom_range(REG_STEP_OVER_INERTIA + 1, 2**CfgIndexW - 1)),
              $urandom());
    write_reg(REG_SPRING_K, k);
    write_reg(REG_DAMPING_B, b);
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_STEP_OVER_INERTIA, soi);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Waits until every owed torque word is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random words sent in bursts with random gaps. Most follow a smooth wheel
  // trajectory so that the mass state evolves as in real use; the rest are
  // full-range noise and jumps to the ends of the range.
  task automatic run_words(input int n);
    int burst_left;
    int gap;
    int pick;
    logic signed [31:0] a;
    logic signed [31:0] v;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        traj_vel = traj_vel + $signed($urandom_range(0, 2**20)) - 2**19;
        traj_ang = traj_ang + (traj_vel >>> 8);
        if (traj_ang > 2**28 || traj_ang < -(2**28) || traj_vel > 2**27 ||
            traj_vel < -(2**27)) begin
          traj_ang = 0;
          traj_vel = 0;
        end
        a = traj_ang;
        v = traj_vel + $signed($urandom_range(0, 2**12)) - 2**11;
      end else if (pick < 85) begin
        a = $urandom();
        v = $urandom();
      end else begin
        a = Extremes[$urandom_range(0, 4)];
        v = Extremes[$urandom_range(0, 4)];
      end
      send_word(a, v);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset coefficients: every pairing of the range
    // ends, zero and plus or minus one. Large angle gaps drive the spring
    // product and the torque sum into saturation.
    foreach (Extremes[i]) begin
      foreach (Extremes[j]) begin
        send_word(Extremes[i], Extremes[j]);
      end
    end
    drain();

    // Random phases, each under its own coefficient set. The first three are
    // the reset values written back, all ones and all zeros.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(SpringKReset, DampingBReset, TimeStepReset, StepOverInertiaReset);
        1: apply_setting('1, '1, '1, '1);
        2: apply_setting('0, '0, '0, '0);
        3: apply_setting($urandom(), $urandom(), $urandom(), $urandom());
        default: apply_setting($urandom_range(0, 2**24), $urandom_range(0, 2**20),
                               $urandom_range(0, 2**26), $urandom_range(0, 2**28));
      endcase
      // Twice in the run the receiver holds off for a long stretch while the
      // sender keeps offering words.
      if (ph == 4 || ph == 7) begin
        hold_reqs <= hold_reqs + 1;
      end
      run_words(PhaseWords);
      drain();
    end

    $display("Checked %0d torque words over %0d coefficient sets after the reset set,",
             sb.words_checked, settings_applied);
    $display("with range-end inputs, saturation, unused register writes and output hold-offs.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("haptic_spring_mass_damper_sim_top: match");
    end else begin
      $display("haptic_spring_mass_damper_sim_top: mismatch");
    end
    $finish;
  end
endmodule
